>>> design/cpic_pkg.sv
package cpic_pkg;

    // Operation codes carried on the op field of an input transaction.
    localparam logic [1:0] OP_QUERY       = 2'd0;
    localparam logic [1:0] OP_WRITE_ADDR  = 2'd1;
    localparam logic [1:0] OP_WRITE_PORT  = 2'd2;
    localparam logic [1:0] OP_WRITE_PROTO = 2'd3;

    localparam logic [7:0] V4_MAX_PREFIX = 8'd32;
    localparam logic [7:0] V6_MAX_PREFIX = 8'd128;

    // Protocol code that skips the protocol check in a query.
    localparam logic [1:0] PROTO_ANY = 2'd0;

    typedef enum logic [1:0] {
        CMD_QUERY,
        CMD_WR_ADDR,
        CMD_WR_PORT,
        CMD_WR_PROTO
    } cmd_kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_DONE
    } state_t;

    // One decoded transaction as it travels from the front end to the engine.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [3:0]  idx;
        logic        ent_valid;
        logic        fam;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [7:0]  plen;
        logic [15:0] plo;
        logic [15:0] phi;
        logic [1:0]  proto;
    } cmd_t;

    function automatic logic [7:0] clamp_prefix(input logic [7:0] len, input logic fam);
        logic [7:0] lim;
        lim = fam ? V6_MAX_PREFIX : V4_MAX_PREFIX;
        return (len > lim) ? lim : len;
    endfunction

    // Network mask over the 128-bit address word for an already clamped length.
    // IPv4 uses the low 32 bits of the low word.
    function automatic logic [127:0] prefix_mask(input logic [7:0] len, input logic fam);
        logic [127:0] m6;
        logic [31:0]  m4;
        m6 = ~({128{1'b1}} >> len);
        m4 = ~({32{1'b1}} >> len);
        return fam ? m6 : {96'd0, m4};
    endfunction

endpackage

>>> design/cidr_port_intercept_classifier.sv
// Address, port and protocol classifier. Each input transaction is either a
// table write (address prefix slot, port range slot or protocol slot) or a
// query; writes produce no result and each query produces exactly one result
// transaction, in order. A query matches when its protocol is allowed (code 0
// means any), when a valid address entry of the same family with a prefix no
// longer than the query's covers the query's masked address bits, and when a
// valid port range covers the queried port; the result carries the smallest
// prefix difference, the narrowest covering port width, and the two packed
// into score. A front end decodes transactions into a two-deep queue, so the
// input keeps flowing until that queue fills while the engine walks a table
// or while a result waits in the output register. A write is applied as it
// leaves the queue while the engine is idle. A query passes through the
// engine in order: it starts, reads each table slot from the address and
// port memories side by side through their single read ports, evaluates the
// last slot, and loads the output register once that register is free.
// Writes to a slot beyond a table's size are discarded. After reset all
// slots are invalid; no clearing pass is needed.
module cidr_port_intercept_classifier
    import cpic_pkg::*;
#(
    parameter int ADDR_ENTRIES  = 16,
    parameter int PORT_ENTRIES  = 16,
    parameter int PROTO_ENTRIES = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [3:0]  entry_index,
    input  logic        entry_valid,
    input  logic        family,
    input  logic [63:0] addr_hi,
    input  logic [63:0] addr_lo,
    input  logic [7:0]  prefix_len,
    input  logic [15:0] port_low,
    input  logic [15:0] port_high,
    input  logic [1:0]  protocol,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        matched,
    output logic [7:0]  addr_score,
    output logic [15:0] port_score,
    output logic [23:0] score
);

    // Decoded command handed from the queue head to the engine.
    logic head_valid;
    cmd_t head;
    logic pop;

    cpic_front #(
        .ADDR_ENTRIES  (ADDR_ENTRIES),
        .PORT_ENTRIES  (PORT_ENTRIES),
        .PROTO_ENTRIES (PROTO_ENTRIES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .entry_index (entry_index),
        .entry_valid (entry_valid),
        .family      (family),
        .addr_hi     (addr_hi),
        .addr_lo     (addr_lo),
        .prefix_len  (prefix_len),
        .port_low    (port_low),
        .port_high   (port_high),
        .protocol    (protocol),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop)
    );

    // The engine owns the tables, so writes and queries are applied strictly
    // in arrival order.
    cpic_back #(
        .ADDR_ENTRIES  (ADDR_ENTRIES),
        .PORT_ENTRIES  (PORT_ENTRIES),
        .PROTO_ENTRIES (PROTO_ENTRIES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .matched    (matched),
        .addr_score (addr_score),
        .port_score (port_score),
        .score      (score)
    );

endmodule

>>> design/cpic_front.sv
module cpic_front
    import cpic_pkg::*;
#(
    parameter int ADDR_ENTRIES  = 16,
    parameter int PORT_ENTRIES  = 16,
    parameter int PROTO_ENTRIES = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [3:0]  entry_index,
    input  logic        entry_valid,
    input  logic        family,
    input  logic [63:0] addr_hi,
    input  logic [63:0] addr_lo,
    input  logic [7:0]  prefix_len,
    input  logic [15:0] port_low,
    input  logic [15:0] port_high,
    input  logic [1:0]  protocol,
    output logic        head_valid,
    output cmd_t        head,
    input  logic        pop
);

    localparam int QDEPTH = 2;

    cmd_t       queue_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    cmd_t cmd;
    logic keep;
    logic accept;
    logic push;
    logic do_pop;

    // Classify the incoming transaction. Writes to a slot beyond a table are
    // dropped here and never reach the engine.
    always_comb
    begin
        cmd.idx       = entry_index;
        cmd.ent_valid = entry_valid;
        cmd.fam       = family;
        cmd.hi        = addr_hi;
        cmd.lo        = addr_lo;
        cmd.plen      = prefix_len;
        cmd.plo       = port_low;
        cmd.phi       = port_high;
        cmd.proto     = protocol;
        unique case (op)
            OP_QUERY:
            begin
                cmd.kind = CMD_QUERY;
                keep     = 1'b1;
                cmd.plen = clamp_prefix(prefix_len, family);
                if (!family)
                begin
                    cmd.lo = {32'd0, addr_lo[31:0]};
                end
            end
            OP_WRITE_ADDR:
            begin
                cmd.kind = CMD_WR_ADDR;
                keep     = int'(entry_index) < ADDR_ENTRIES;
            end
            OP_WRITE_PORT:
            begin
                cmd.kind = CMD_WR_PORT;
                keep     = int'(entry_index) < PORT_ENTRIES;
            end
            OP_WRITE_PROTO:
            begin
                cmd.kind = CMD_WR_PROTO;
                keep     = int'(entry_index) < PROTO_ENTRIES;
            end
            default:
            begin
                cmd.kind = CMD_QUERY;
                keep     = 1'b0;
            end
        endcase
    end

    assign in_stall   = (count_reg == 2'(QDEPTH));
    assign accept     = in_valid && !in_stall;
    assign push       = accept && keep;
    assign head_valid = (count_reg != 2'd0);
    assign do_pop     = pop && head_valid;
    assign head       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

>>> design/cpic_back.sv
module cpic_back
    import cpic_pkg::*;
#(
    parameter int ADDR_ENTRIES  = 16,
    parameter int PORT_ENTRIES  = 16,
    parameter int PROTO_ENTRIES = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  cmd_t        head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        matched,
    output logic [7:0]  addr_score,
    output logic [15:0] port_score,
    output logic [23:0] score
);

    localparam int AW     = (ADDR_ENTRIES > 1) ? $clog2(ADDR_ENTRIES) : 1;
    localparam int PW     = (PORT_ENTRIES > 1) ? $clog2(PORT_ENTRIES) : 1;
    localparam int RW     = (PROTO_ENTRIES > 1) ? $clog2(PROTO_ENTRIES) : 1;
    localparam int WALK_N = (ADDR_ENTRIES > PORT_ENTRIES) ? ADDR_ENTRIES : PORT_ENTRIES;
    localparam int CW     = (WALK_N > 1) ? $clog2(WALK_N) : 1;

    // Table storage: address and port data in memories, valid bits and protocol codes in flip-flops.
    logic [63:0] a_hi_mem  [ADDR_ENTRIES];
    logic [63:0] a_lo_mem  [ADDR_ENTRIES];
    logic [7:0]  a_len_mem [ADDR_ENTRIES];
    logic        a_fam_mem [ADDR_ENTRIES];
    logic [15:0] p_lo_mem  [PORT_ENTRIES];
    logic [15:0] p_hi_mem  [PORT_ENTRIES];
    logic [ADDR_ENTRIES-1:0]  a_vld_reg;
    logic [PORT_ENTRIES-1:0]  p_vld_reg;
    logic [PROTO_ENTRIES-1:0] r_vld_reg;
    logic [1:0]               r_ent_reg [PROTO_ENTRIES];

    state_t state_reg, state_next;
    logic   start, rd_issue, load_out, out_free;
    logic   wr_addr, wr_port, wr_proto;

    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] a_idx;
    logic [PW-1:0] p_idx;
    logic          a_in_range, p_in_range;

    // Query held for the duration of the walk.
    logic          q_fam_reg;
    logic [63:0]   q_hi_reg, q_lo_reg;
    logic [7:0]    q_len_reg;
    logic [15:0]   q_port_reg;
    logic          proto_ok_reg;
    logic          proto_hit;

    // Read stage.
    logic          eval_reg;
    logic          rd_a_vld_reg, rd_p_vld_reg;
    logic [63:0]   rd_a_hi_reg, rd_a_lo_reg;
    logic [7:0]    rd_a_len_reg;
    logic          rd_a_fam_reg;
    logic [15:0]   rd_p_lo_reg, rd_p_hi_reg;

    // Running best over the walk.
    logic          have_a_reg, have_p_reg;
    logic [7:0]    best_a_reg;
    logic [15:0]   best_p_reg;

    logic [7:0]    rlen, a_diff;
    logic [127:0]  a_mask;
    logic          a_hit, p_hit;
    logic [15:0]   p_diff;

    logic          out_valid_reg, matched_reg;
    logic [7:0]    addr_score_reg;
    logic [15:0]   port_score_reg;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid && head.kind == CMD_QUERY)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (cnt_reg == CW'(WALK_N - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        start    = 1'b0;
        wr_addr  = 1'b0;
        wr_port  = 1'b0;
        wr_proto = 1'b0;
        rd_issue = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                pop      = head_valid;
                start    = head_valid && head.kind == CMD_QUERY;
                wr_addr  = head_valid && head.kind == CMD_WR_ADDR;
                wr_port  = head_valid && head.kind == CMD_WR_PORT;
                wr_proto = head_valid && head.kind == CMD_WR_PROTO;
            end
            S_WALK:
            begin
                rd_issue = 1'b1;
            end
            S_DRAIN:
            begin
            end
            S_DONE:
            begin
                load_out = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Protocol lookup is done in parallel over the small table at query start.
    always_comb
    begin
        proto_hit = (head.proto == PROTO_ANY);
        for (int i = 0; i < PROTO_ENTRIES; i++)
        begin
            if (r_vld_reg[i] && r_ent_reg[i] == head.proto)
            begin
                proto_hit = 1'b1;
            end
        end
    end

    assign a_in_range = int'(cnt_reg) < ADDR_ENTRIES;
    assign p_in_range = int'(cnt_reg) < PORT_ENTRIES;
    assign a_idx      = a_in_range ? AW'(cnt_reg) : '0;
    assign p_idx      = p_in_range ? PW'(cnt_reg) : '0;

    always_ff @(posedge clk)
    begin
        if (wr_addr)
        begin
            a_hi_mem[AW'(head.idx)]  <= head.hi;
            a_lo_mem[AW'(head.idx)]  <= head.lo;
            a_len_mem[AW'(head.idx)] <= head.plen;
            a_fam_mem[AW'(head.idx)] <= head.fam;
        end
        if (rd_issue)
        begin
            rd_a_hi_reg  <= a_hi_mem[a_idx];
            rd_a_lo_reg  <= a_lo_mem[a_idx];
            rd_a_len_reg <= a_len_mem[a_idx];
            rd_a_fam_reg <= a_fam_mem[a_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_port)
        begin
            p_lo_mem[PW'(head.idx)] <= head.plo;
            p_hi_mem[PW'(head.idx)] <= head.phi;
        end
        if (rd_issue)
        begin
            rd_p_lo_reg <= p_lo_mem[p_idx];
            rd_p_hi_reg <= p_hi_mem[p_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_proto)
        begin
            r_ent_reg[RW'(head.idx)] <= head.proto;
        end
        if (start)
        begin
            q_fam_reg  <= head.fam;
            q_hi_reg   <= head.hi;
            q_lo_reg   <= head.lo;
            q_len_reg  <= head.plen;
            q_port_reg <= head.plo;
        end
    end

    // Evaluate the entry read in the previous cycle.
    always_comb
    begin
        rlen   = clamp_prefix(rd_a_len_reg, q_fam_reg);
        a_mask = prefix_mask(rlen, q_fam_reg);
        a_diff = q_len_reg - rlen;
        a_hit  = rd_a_vld_reg && (rd_a_fam_reg == q_fam_reg) && (q_len_reg >= rlen)
                 && ((({q_hi_reg, q_lo_reg} ^ {rd_a_hi_reg, rd_a_lo_reg}) & a_mask) == '0);
        p_diff = rd_p_hi_reg - rd_p_lo_reg;
        p_hit  = rd_p_vld_reg && (rd_p_lo_reg <= q_port_reg) && (q_port_reg <= rd_p_hi_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg      <= '0;
            p_vld_reg      <= '0;
            r_vld_reg      <= '0;
            cnt_reg        <= '0;
            eval_reg       <= 1'b0;
            rd_a_vld_reg   <= 1'b0;
            rd_p_vld_reg   <= 1'b0;
            have_a_reg     <= 1'b0;
            have_p_reg     <= 1'b0;
            best_a_reg     <= '0;
            best_p_reg     <= '0;
            proto_ok_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            matched_reg    <= 1'b0;
            addr_score_reg <= '0;
            port_score_reg <= '0;
        end
        else
        begin
            if (wr_addr)
            begin
                a_vld_reg[AW'(head.idx)] <= head.ent_valid;
            end
            if (wr_port)
            begin
                p_vld_reg[PW'(head.idx)] <= head.ent_valid;
            end
            if (wr_proto)
            begin
                r_vld_reg[RW'(head.idx)] <= head.ent_valid;
            end

            eval_reg     <= rd_issue;
            rd_a_vld_reg <= rd_issue && a_in_range && a_vld_reg[a_idx];
            rd_p_vld_reg <= rd_issue && p_in_range && p_vld_reg[p_idx];

            if (start)
            begin
                cnt_reg      <= '0;
                have_a_reg   <= 1'b0;
                have_p_reg   <= 1'b0;
                best_a_reg   <= '0;
                best_p_reg   <= '0;
                proto_ok_reg <= proto_hit;
            end
            else
            begin
                if (rd_issue)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (eval_reg && a_hit)
                begin
                    have_a_reg <= 1'b1;
                    if (!have_a_reg || a_diff < best_a_reg)
                    begin
                        best_a_reg <= a_diff;
                    end
                end
                if (eval_reg && p_hit)
                begin
                    have_p_reg <= 1'b1;
                    if (!have_p_reg || p_diff < best_p_reg)
                    begin
                        best_p_reg <= p_diff;
                    end
                end
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                matched_reg   <= proto_ok_reg && have_a_reg && have_p_reg;
                if (proto_ok_reg && have_a_reg && have_p_reg)
                begin
                    addr_score_reg <= best_a_reg;
                    port_score_reg <= best_p_reg;
                end
                else
                begin
                    addr_score_reg <= '0;
                    port_score_reg <= '0;
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign matched    = matched_reg;
    assign addr_score = addr_score_reg;
    assign port_score = port_score_reg;
    assign score      = {addr_score_reg, port_score_reg};

    // The queue is only drained while the engine is idle.
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == S_IDLE))
        else $error("command popped while engine busy");

    // A new result only appears after a finished walk.
    a_out_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result presented without a completed query");

    // A miss reports zero scores.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !matched_reg) |-> (addr_score_reg == 8'd0 && port_score_reg == 16'd0))
        else $error("nonzero score on a miss");

    // The address difference can never exceed the longest IPv6 prefix.
    a_addr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        have_a_reg |-> (best_a_reg <= V6_MAX_PREFIX))
        else $error("address score out of range");

endmodule

>>> tb/sv/cidr_port_intercept_classifier_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the CIDR, port-range and protocol classifier.
//
// Every input transaction that the block accepts is also applied to a
// behavioral copy of the three tables kept in this module. Table writes
// update that copy. Queries are evaluated against it, and the expected
// verdict is queued. Each result transaction that the block hands over is
// compared field by field with the oldest queued verdict.
//
// The stimulus opens with a short table of hand-written transactions. Some of
// its rows carry a verdict worked out by hand, and those values are queued in
// place of the computed ones. The random part follows, and most of its queries
// are aimed at slots that are already loaded so that many of them hit.
module cidr_port_intercept_classifier_tb;
    import cpic_pkg::*;

    // Table sizes of the default build of the block.
    localparam int ADDR_SLOTS  = 16;
    localparam int PORT_SLOTS  = 16;
    localparam int PROTO_SLOTS = 4;

    localparam int RANDOM_TXNS     = 1600;
    // Cycles with no handshake on either side before the run is declared hung.
    localparam int QUIET_LIMIT     = 2000;
    // Extra wait at the end so that any stray extra result still shows up.
    localparam int DRAIN_CYCLES    = 60;
    localparam int LOUD_MISMATCHES = 10;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  idx;
        logic        ev;
        logic        fam;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [7:0]  plen;
        logic [15:0] plo;
        logic [15:0] phi;
        logic [1:0]  proto;
    } txn_t;

    typedef struct packed {
        logic        matched;
        logic [7:0]  addr_score;
        logic [15:0] port_score;
        logic [23:0] score;
    } verdict_t;

    // One row of the directed table. When gold_on is set, gold is the verdict
    // worked out by hand for that query.
    typedef struct packed {
        txn_t     t;
        logic     gold_on;
        verdict_t gold;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  op;
    logic [3:0]  entry_index;
    logic        entry_valid;
    logic        family;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  prefix_len;
    logic [15:0] port_low;
    logic [15:0] port_high;
    logic [1:0]  protocol;
    logic        out_valid;
    logic        out_stall;
    logic        matched;
    logic [7:0]  addr_score;
    logic [15:0] port_score;
    logic [23:0] score;

    cidr_port_intercept_classifier DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .entry_index (entry_index),
        .entry_valid (entry_valid),
        .family      (family),
        .addr_hi     (addr_hi),
        .addr_lo     (addr_lo),
        .prefix_len  (prefix_len),
        .port_low    (port_low),
        .port_high   (port_high),
        .protocol    (protocol),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .matched     (matched),
        .addr_score  (addr_score),
        .port_score  (port_score),
        .score       (score)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Bench copy of the tables. Address entries keep the full 128-bit word.
    // An IPv4 entry only ever compares its low 32 bits.
    logic [127:0] rng_word [ADDR_SLOTS];
    logic [7:0]   rng_len  [ADDR_SLOTS];
    logic         rng_fam  [ADDR_SLOTS];
    logic         rng_on   [ADDR_SLOTS];
    logic [15:0]  prt_lo   [PORT_SLOTS];
    logic [15:0]  prt_hi   [PORT_SLOTS];
    logic         prt_on   [PORT_SLOTS];
    logic [1:0]   pro_code [PROTO_SLOTS];
    logic         pro_on   [PROTO_SLOTS];

    verdict_t verdicts_due [$];
    int       mismatches = 0;
    int       quiet_cycles = 0;

    // Sender pacing. Mode 0 sends back to back. Mode 1 sends medium bursts with
    // short gaps. Mode 2 sends short bursts with long gaps.
    int pace_mode = 1;
    int burst_left = 0;

    // Receiver stall pattern state.
    int stall_mode = 0;
    int stall_span = 0;
    int stall_tick = 0;

    initial
    begin
        for (int i = 0; i < ADDR_SLOTS; i++)
        begin
            rng_word[i] = '0;
            rng_len[i]  = '0;
            rng_fam[i]  = 1'b0;
            rng_on[i]   = 1'b0;
        end
        for (int i = 0; i < PORT_SLOTS; i++)
        begin
            prt_lo[i] = '0;
            prt_hi[i] = '0;
            prt_on[i] = 1'b0;
        end
        for (int i = 0; i < PROTO_SLOTS; i++)
        begin
            pro_code[i] = '0;
            pro_on[i]   = 1'b0;
        end
    end

    // Prefix lengths beyond the family's width count as the full width.
    function automatic int unsigned sat_prefix(input logic [7:0] len, input logic fam);
        int unsigned ceiling;
        ceiling = fam ? 128 : 32;
        return (int'(len) > ceiling) ? ceiling : len;
    endfunction

    // Network bits of a 128-bit address word. IPv4 lives in the low 32 bits.
    function automatic logic [127:0] net_mask(input int unsigned len, input logic fam);
        logic [127:0] ones;
        ones = '1;
        if (fam)
            return ones << (128 - len);
        return {96'd0, ones[31:0] << (32 - len)};
    endfunction

    // Verdict for a query against the current bench tables.
    function automatic verdict_t lookup_verdict(input txn_t t);
        verdict_t     v;
        logic         proto_ok;
        logic         have_a;
        logic         have_p;
        int unsigned  qlen;
        int unsigned  rlen;
        int unsigned  best_a;
        int unsigned  best_p;
        int unsigned  width;
        logic [127:0] qaddr;
        int           i;
        v = '0;
        proto_ok = (t.proto == PROTO_ANY);
        for (i = 0; i < PROTO_SLOTS; i++)
            if (pro_on[i] && pro_code[i] == t.proto)
                proto_ok = 1'b1;

        qaddr = t.fam ? {t.hi, t.lo} : {96'd0, t.lo[31:0]};
        qlen = sat_prefix(t.plen, t.fam);
        have_a = 1'b0;
        best_a = 0;
        for (i = 0; i < ADDR_SLOTS; i++)
        begin
            if (rng_on[i] && rng_fam[i] == t.fam)
            begin
                rlen = sat_prefix(rng_len[i], t.fam);
                if (qlen >= rlen && ((qaddr ^ rng_word[i]) & net_mask(rlen, t.fam)) == '0)
                begin
                    if (!have_a || qlen - rlen < best_a)
                        best_a = qlen - rlen;
                    have_a = 1'b1;
                end
            end
        end

        have_p = 1'b0;
        best_p = 0;
        for (i = 0; i < PORT_SLOTS; i++)
        begin
            if (prt_on[i] && prt_lo[i] <= t.plo && t.plo <= prt_hi[i])
            begin
                width = prt_hi[i] - prt_lo[i];
                if (!have_p || width < best_p)
                    best_p = width;
                have_p = 1'b1;
            end
        end

        if (proto_ok && have_a && have_p)
        begin
            v.matched    = 1'b1;
            v.addr_score = best_a[7:0];
            v.port_score = best_p[15:0];
            v.score      = {v.addr_score, v.port_score};
        end
        return v;
    endfunction

    // Table writes. The data bits are stored even by a clearing write.
    function automatic void commit_table_write(input txn_t t);
        case (t.op)
            OP_WRITE_ADDR:
            begin
                rng_word[t.idx] = {t.hi, t.lo};
                rng_len[t.idx]  = t.plen;
                rng_fam[t.idx]  = t.fam;
                rng_on[t.idx]   = t.ev;
            end
            OP_WRITE_PORT:
            begin
                prt_lo[t.idx] = t.plo;
                prt_hi[t.idx] = t.phi;
                prt_on[t.idx] = t.ev;
            end
            OP_WRITE_PROTO:
            begin
                // The protocol table is smaller than the index field, so
                // writes to the upper slots are dropped.
                if (t.idx < PROTO_SLOTS)
                begin
                    pro_code[t.idx[1:0]] = t.proto;
                    pro_on[t.idx[1:0]]   = t.ev;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic plan_row_t row_of(input logic [1:0] op_code, input logic [3:0] idx,
                                         input logic ev, input logic fam,
                                         input logic [63:0] hi, input logic [63:0] lo,
                                         input logic [7:0] plen, input logic [15:0] plo,
                                         input logic [15:0] phi, input logic [1:0] proto,
                                         input logic gold_on, input logic gm,
                                         input logic [7:0] ga, input logic [15:0] gp);
        plan_row_t r;
        r.t       = '{op: op_code, idx: idx, ev: ev, fam: fam, hi: hi, lo: lo,
                      plen: plen, plo: plo, phi: phi, proto: proto};
        r.gold_on = gold_on;
        r.gold    = '{matched: gm, addr_score: ga, port_score: gp, score: {ga, gp}};
        return r;
    endfunction

    // Drives one transaction, starting and ending at a falling edge. The
    // transaction is applied to the bench tables at the edge that accepts it.
    task automatic drive_txn(input txn_t t, input logic gold_on, input verdict_t gold);
        if (burst_left == 0)
        begin
            if (pace_mode != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, pace_mode == 1 ? 4 : 20)) @(negedge clk);
            end
            burst_left = (pace_mode == 2) ? $urandom_range(1, 3) : $urandom_range(1, 12);
        end
        burst_left--;

        in_valid    <= 1'b1;
        op          <= t.op;
        entry_index <= t.idx;
        entry_valid <= t.ev;
        family      <= t.fam;
        addr_hi     <= t.hi;
        addr_lo     <= t.lo;
        prefix_len  <= t.plen;
        port_low    <= t.plo;
        port_high   <= t.phi;
        protocol    <= t.proto;

        // in_stall is read right after the edge, before the block updates it.
        do
            @(posedge clk);
        while (in_stall);

        if (t.op == OP_QUERY)
            verdicts_due.push_back(gold_on ? gold : lookup_verdict(t));
        else
            commit_table_write(t);
        @(negedge clk);
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= LOUD_MISMATCHES)
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    endtask

    // Result checker. The outputs are sampled at the rising edge, and every
    // accepted result must line up with the oldest queued verdict.
    always @(posedge clk)
    begin : check_results
        verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdicts_due.size() == 0)
            begin
                flag_mismatch("unexpected result (score)", '0, score);
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (matched !== want.matched)
                    flag_mismatch("matched", want.matched, matched);
                if (addr_score !== want.addr_score)
                    flag_mismatch("addr_score", want.addr_score, addr_score);
                if (port_score !== want.port_score)
                    flag_mismatch("port_score", want.port_score, port_score);
                if (score !== want.score)
                    flag_mismatch("score", want.score, score);
            end
        end
    end

    // Receiver stall pattern. Stretches of random length alternate between
    // never stalling, light and heavy random stalls, and a periodic burst.
    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(50, 400);
        end
        else
        begin
            stall_span--;
        end
        stall_tick++;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 99) < 30);
            2:       out_stall <= ($urandom_range(0, 99) < 75);
            default: out_stall <= ((stall_tick % 23) < 9);
        endcase
    end

    // Watchdog: a run in which neither side completes a handshake for too long
    // has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[cidr_port_intercept_classifier] ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        plan_row_t    plan [$];
        txn_t         t;
        logic [127:0] m;
        int unsigned  rl;
        int unsigned  ql;
        int unsigned  span;
        logic [3:0]   s;
        int           pick;
        int           shape;
        int           done_txns;
        int           k;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        out_stall   = 1'b0;
        op          = OP_QUERY;
        entry_index = '0;
        entry_valid = 1'b0;
        family      = 1'b0;
        addr_hi     = '0;
        addr_lo     = '0;
        prefix_len  = '0;
        port_low    = '0;
        port_high   = '0;
        protocol    = PROTO_ANY;

        // Directed table. The tables start empty, so the first query cannot
        // match. Protocol 2 and protocol 0 are stored, and a protocol write to a
        // slot beyond the table is dropped. Port ranges include the full range,
        // a single port and an inverted range that covers nothing.
        plan.push_back(row_of(OP_QUERY, 4'd0, 1'b0, 1'b0, 64'd0, 64'h0A010203, 8'd32,
                              16'd80, 16'd0, PROTO_ANY, 1'b1, 1'b0, 8'd0, 16'd0));
        plan.push_back(row_of(OP_WRITE_PROTO, 4'd0, 1'b1, 1'b0, 64'd0, 64'd0, 8'd0,
                              16'd0, 16'd0, 2'd2, 1'b0, 1'b0, 8'd0, 16'd0));
        plan.push_back(row_of(OP_WRITE_PROTO, 4'd15, 1'b1, 1'b0, 64'd0, 64'd0, 8'd0,
                              16'd0, 16'd0, 2'd3, 1'b0, 1'b0, 8'd0, 16'd0));
        plan.push_back(row_of(OP_WRITE_PROTO, 4'd3, 1'b1, 1'b1, '1, '1, 8'hFF,
                              16'hFFFF, 16'hFFFF, PROTO_ANY, 1'b0, 1'b0, 8'd0, 16'd0));
        plan.push_back(row_of(OP_WRITE_PORT, 4'd0, 1'b1, 1'b0, 64'd0, 64'd0, 8'd0,
                              16'd0, 16'hFFFF, 2'd0, 1'b0, 1'b0, 8'd0, 16'd0));
        plan.push_back(row_of(OP_WRITE_PORT, 4'd15, 1'b1, 1'b0, 64'd0, 64'd0, 8'd0,
                              16'd80, 16'd80, 2'd0, 1'b0, 1'b0, 8'd0, 16'd0));
        plan.push_back(row_of(OP_WRITE_PORT, 4'd5, 1'b1, 1'b0, 64'd0, 64'd0, 8'd0,
                              16'd1000, 16'd10, 2'd0, 1'b0, 1'b0, 8'd0, 16'd0));
        // The IPv4 entry carries junk in addr_hi and in the top of addr_lo.
        plan.push_back(row_of(OP_WRITE_ADDR, 4'd0, 1'b1, 1'b0, '1, 64'hFFFFFFFF_0A000000,
                              8'd8, 16'd0, 16'd0, 2'd0, 1'b0, 1'b0, 8'd0, 16'd0));
        plan.push_back(row_of(OP_WRITE_ADDR, 4'd15, 1'b1, 1'b1, 64'h20010DB8_00000000, 64'd0,
                              8'd32, 16'd0, 16'd0, 2'd0, 1'b0, 1'b0, 8'd0, 16'd0));
        plan.push_back(row_of(OP_WRITE_ADDR, 4'd1, 1'b1, 1'b0, 64'd0, 64'd0, 8'd0,
                              16'd0, 16'd0, 2'd0, 1'b0, 1'b0, 8'd0, 16'd0));
        // 10.1.2.3/32 on port 80, protocol 2: best is the /8 (difference 24)
        // and the single-port range (width 0).
        plan.push_back(row_of(OP_QUERY, 4'd9, 1'b1, 1'b0, '1, 64'hDEADBEEF_0A010203, 8'd32,
                              16'd80, 16'h1234, 2'd2, 1'b1, 1'b1, 8'd24, 16'd0));
        // Protocol 3 only reached the dropped slot.
        plan.push_back(row_of(OP_QUERY, 4'd0, 1'b0, 1'b0, 64'd0, 64'h0A010203, 8'd32,
                              16'd80, 16'd0, 2'd3, 1'b1, 1'b0, 8'd0, 16'd0));
        // IPv6 query with an oversized prefix, which is taken as /128. Port
        // 65535 is covered only by the full range.
        plan.push_back(row_of(OP_QUERY, 4'd0, 1'b0, 1'b1, 64'h20010DB8_00000000, 64'd1,
                              8'hFF, 16'hFFFF, 16'd0, PROTO_ANY, 1'b1, 1'b1, 8'd96, 16'hFFFF));
        // Entry with an oversized prefix, which is taken as /32.
        plan.push_back(row_of(OP_WRITE_ADDR, 4'd2, 1'b1, 1'b0, 64'd0, 64'h0A010203, 8'd200,
                              16'd0, 16'd0, 2'd0, 1'b0, 1'b0, 8'd0, 16'd0));
        plan.push_back(row_of(OP_QUERY, 4'd0, 1'b0, 1'b0, 64'd0, 64'h0A010203, 8'd40,
                              16'd500, 16'd0, 2'd2, 1'b1, 1'b1, 8'd0, 16'hFFFF));
        plan.push_back(row_of(OP_QUERY, 4'd0, 1'b0, 1'b0, 64'd0, 64'h0A01FFFF, 8'd16,
                              16'd80, 16'd0, PROTO_ANY, 1'b0, 1'b0, 8'd0, 16'd0));
        // Clearing writes still carry data, but the slots must stop matching.
        plan.push_back(row_of(OP_WRITE_ADDR, 4'd0, 1'b0, 1'b0, 64'd0, 64'h0A000000, 8'd0,
                              16'd0, 16'd0, 2'd0, 1'b0, 1'b0, 8'd0, 16'd0));
        plan.push_back(row_of(OP_WRITE_ADDR, 4'd1, 1'b0, 1'b0, 64'd0, 64'd0, 8'd0,
                              16'd0, 16'd0, 2'd0, 1'b0, 1'b0, 8'd0, 16'd0));
        plan.push_back(row_of(OP_QUERY, 4'd0, 1'b0, 1'b0, 64'd0, 64'h0A010203, 8'd16,
                              16'd80, 16'd0, PROTO_ANY, 1'b1, 1'b0, 8'd0, 16'd0));
        plan.push_back(row_of(OP_WRITE_PORT, 4'd0, 1'b0, 1'b0, 64'd0, 64'd0, 8'd0,
                              16'd0, 16'hFFFF, 2'd0, 1'b0, 1'b0, 8'd0, 16'd0));
        plan.push_back(row_of(OP_QUERY, 4'd0, 1'b0, 1'b1, 64'h20010DB8_12345678,
                              64'hCAFEF00D_00000001, 8'd64, 16'd80, 16'd0, 2'd2,
                              1'b0, 1'b0, 8'd0, 16'd0));
        plan.push_back(row_of(OP_WRITE_ADDR, 4'd3, 1'b1, 1'b1, '1, '1, 8'd128,
                              16'd0, 16'd0, 2'd0, 1'b0, 1'b0, 8'd0, 16'd0));
        // Protocol 1 is not allowed until it is written below.
        plan.push_back(row_of(OP_QUERY, 4'd0, 1'b0, 1'b1, '1, '1, 8'd128,
                              16'd80, 16'd0, 2'd1, 1'b1, 1'b0, 8'd0, 16'd0));
        plan.push_back(row_of(OP_WRITE_PROTO, 4'd1, 1'b1, 1'b0, 64'd0, 64'd0, 8'd0,
                              16'd0, 16'd0, 2'd1, 1'b0, 1'b0, 8'd0, 16'd0));
        plan.push_back(row_of(OP_QUERY, 4'd0, 1'b0, 1'b1, '1, '1, 8'd128,
                              16'd80, 16'd0, 2'd1, 1'b1, 1'b1, 8'd0, 16'd0));
        // 0.0.0.0/0 is shorter than the only IPv4 entry that is left.
        plan.push_back(row_of(OP_QUERY, 4'd0, 1'b0, 1'b0, 64'd0, 64'd0, 8'd0,
                              16'd0, 16'd0, PROTO_ANY, 1'b1, 1'b0, 8'd0, 16'd0));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        pace_mode = 1;
        for (k = 0; k < plan.size(); k++)
            drive_txn(plan[k].t, plan[k].gold_on, plan[k].gold);

        // Random part. The fields start fully random, and each kind of
        // transaction then shapes the fields it uses.
        done_txns = 0;
        while (done_txns < RANDOM_TXNS)
        begin
            if (done_txns % 100 == 0)
                pace_mode = $urandom_range(0, 2);

            t.hi    = {$urandom, $urandom};
            t.lo    = {$urandom, $urandom};
            t.idx   = 4'($urandom_range(0, 15));
            t.ev    = ($urandom_range(0, 99) < 85);
            t.fam   = 1'($urandom_range(0, 1));
            t.plen  = 8'($urandom);
            t.plo   = 16'($urandom);
            t.phi   = 16'($urandom);
            t.proto = 2'($urandom);
            pick    = $urandom_range(0, 99);

            if (pick < 58)
            begin
                t.op = OP_QUERY;
                shape = $urandom_range(0, 99);
                if (shape < 75)
                begin
                    // Take the network bits of a stored slot and randomize the
                    // host bits, with a query prefix at or a bit beyond the
                    // slot's own prefix.
                    s     = 4'($urandom_range(0, ADDR_SLOTS - 1));
                    t.fam = rng_fam[s];
                    rl    = sat_prefix(rng_len[s], t.fam);
                    m     = net_mask(rl, t.fam);
                    {t.hi, t.lo} = (rng_word[s] & m) | ({t.hi, t.lo} & ~m);
                    ql = rl + $urandom_range(0, 8);
                    if (ql > (t.fam ? 128 : 32))
                        ql = t.fam ? 128 : 32;
                    if ($urandom_range(0, 9) != 0)
                        t.plen = 8'(ql);
                end
                else if (shape < 90)
                begin
                    t.plen = 8'(t.fam ? $urandom_range(0, 128) : $urandom_range(0, 32));
                end
                if ($urandom_range(0, 99) < 75)
                begin
                    s = 4'($urandom_range(0, PORT_SLOTS - 1));
                    if (prt_lo[s] <= prt_hi[s])
                        t.plo = prt_lo[s] + 16'($urandom_range(0, prt_hi[s] - prt_lo[s]));
                end
                if ($urandom_range(0, 99) < 35)
                    t.proto = PROTO_ANY;
            end
            else if (pick < 75)
            begin
                t.op = OP_WRITE_ADDR;
                if ($urandom_range(0, 99) < 85)
                    t.plen = 8'(t.fam ? $urandom_range(0, 128) : $urandom_range(0, 32));
            end
            else if (pick < 90)
            begin
                t.op  = OP_WRITE_PORT;
                shape = $urandom_range(0, 99);
                span  = 0;
                if (shape < 40)
                begin
                    span = $urandom_range(0, 15);
                end
                else if (shape < 75)
                begin
                    span = $urandom_range(0, 4095);
                end
                else if (shape < 90)
                begin
                    t.plo = 16'($urandom_range(0, 3));
                    span  = 65535;
                end
                // The remaining writes keep a random high bound, which is often
                // below the low bound.
                if (shape < 90)
                    t.phi = (t.plo + span > 65535) ? 16'hFFFF : 16'(t.plo + span);
            end
            else
            begin
                t.op = OP_WRITE_PROTO;
                if ($urandom_range(0, 1) != 0)
                    t.idx = 4'($urandom_range(0, PROTO_SLOTS - 1));
            end

            drive_txn(t, 1'b0, '0);
            // A dropped protocol write does nothing, so it does not count.
            if (!(t.op == OP_WRITE_PROTO && t.idx >= PROTO_SLOTS))
                done_txns++;
        end

        in_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("[cidr_port_intercept_classifier] OK");
        else
            $display("[cidr_port_intercept_classifier] ERROR");
        $finish;
    end

endmodule
